@@ rtl/rtfr_pkg.sv @@
// shared types, constants and font table of the rotated text framebuffer renderer
package rtfr_pkg;

	localparam int LOGICAL_WIDTH_DEF  = 64;
	localparam int LOGICAL_HEIGHT_DEF = 128;
	localparam int FRAME_BYTES_DEF    = 1024;

	localparam logic [2:0] GLYPH_LAST_COL = 3'd4;
	localparam logic [2:0] GAP_COL        = 3'd5;
	localparam logic [2:0] GLYPH_LAST_ROW = 3'd6;
	localparam logic [7:0] FIRST_CODE     = 8'd32;
	localparam logic [7:0] LAST_CODE      = 8'd126;
	localparam logic [7:0] FALLBACK_CODE  = 8'd63;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_PIXEL = 2'd1,
		OP_CHAR  = 2'd2,
		OP_READ  = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_PIX_RD,
		ST_PIX_WR,
		ST_CHR_START,
		ST_CHR_WRAP,
		ST_CHR_CHECK,
		ST_DOT_RD,
		ST_DOT_WR,
		ST_CHR_ADV,
		ST_BYTE_RD,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SRC_SWEEP,
		SRC_DOT,
		SRC_BYTE
	} addr_src_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic      accept;
		logic      rd_en;
		logic      wr_en;
		addr_src_t src;
		logic      fill_zero;
		logic      dot_next;
		logic      chr_start;
		logic      chr_wrap;
		logic      chr_stop;
		logic      chr_adv;
		logic      out_load;
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		opcode_t op;
		logic    stopped;
		logic    too_tall;
		logic    scale_zero;
		logic    dot_last;
		logic    sweep_last;
		logic    out_busy;
	} dp_status_t;

	// 5x7 font, codes 32 to 126, first byte is column 0, bit r is row r
	localparam logic [0:4][7:0] GLYPH_ROM [95] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700,
		40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
		40'h3649552250, 40'h0005030000, 40'h001C224100,
		40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000,
		40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
		40'h4261514946, 40'h2141454B31, 40'h1814127F10,
		40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036360000,
		40'h0056360000, 40'h0814224100, 40'h1414141414,
		40'h0041221408, 40'h0201510906, 40'h324979413E,
		40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
		40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
		40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
		40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
		40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
		40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
		40'h0708700807, 40'h6151494543, 40'h007F414100,
		40'h0204081020, 40'h0041417F00, 40'h0402010204,
		40'h4040404040, 40'h0001020400, 40'h2054545478,
		40'h7F48444438, 40'h3844444420, 40'h384444487F,
		40'h3854545418, 40'h087E090102, 40'h0C5252523E,
		40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
		40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
		40'h7C08040478, 40'h3844444438, 40'h7C14141408,
		40'h081414147C, 40'h7C08040408, 40'h4854545420,
		40'h043F444020, 40'h3C4040407C, 40'h1C2040201C,
		40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
		40'h4464544C44, 40'h0008364100, 40'h00007F0000,
		40'h0041360800, 40'h08082A1C08
	};

	// one font column; codes outside the printable range fall back to '?'
	function automatic logic [7:0] glyph_column(input logic [7:0] code, input logic [2:0] col);
		logic [7:0] c;
		logic [6:0] idx;
		c = (code < FIRST_CODE || code > LAST_CODE) ? FALLBACK_CODE : code;
		idx = 7'(c - FIRST_CODE);
		if (col > GLYPH_LAST_COL) begin
			return 8'h00;
		end
		return GLYPH_ROM[idx][col];
	endfunction

endpackage

@@ rtl/rtfr_cmd_if.sv @@
// valid/ready channels carrying request and result items
interface rtfr_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] pos_x;
	logic [7:0] pos_y;
	logic       string_start;
	logic [7:0] char_code;
	logic       ink;
	logic [3:0] glyph_scale;
	logic [9:0] byte_address;

	modport source (output valid, opcode, pos_x, pos_y, string_start, char_code, ink,
		glyph_scale, byte_address, input ready);
	modport sink (input valid, opcode, pos_x, pos_y, string_start, char_code, ink,
		glyph_scale, byte_address, output ready);
endinterface

interface rtfr_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] next_x;
	logic       char_drawn;
	logic [7:0] read_data;

	modport source (output valid, next_x, char_drawn, read_data, input ready);
	modport sink (input valid, next_x, char_drawn, read_data, output ready);
endinterface

@@ rtl/rtfr_ctrl.sv @@
// controller state machine sequencing clear, pixel, character and read operations
module rtfr_ctrl
	import rtfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.src  = SRC_DOT;
		in_ready = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.wr_en     = 1'b1;
				cmd.src       = SRC_SWEEP;
				cmd.fill_zero = 1'b1;
				if (status.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
				end
				if (in_valid) begin
					// decode the opcode from the stored copy via datapath status next cycle
					state_d = ST_CHR_START;
				end
			end
			ST_CHR_START: begin
				// first cycle after a transfer: dispatch on the stored opcode
				unique case (status.op)
					OP_CLEAR: state_d = ST_CLEAR;
					OP_PIXEL: state_d = ST_PIX_RD;
					OP_READ:  state_d = ST_BYTE_RD;
					default: begin
						cmd.chr_start = 1'b1;
						state_d       = ST_CHR_WRAP;
					end
				endcase
			end
			ST_CLEAR: begin
				cmd.wr_en = 1'b1;
				cmd.src   = SRC_SWEEP;
				if (status.sweep_last) state_d = ST_DONE;
			end
			ST_PIX_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_PIX_WR;
			end
			ST_PIX_WR: begin
				cmd.wr_en = 1'b1;
				state_d   = ST_DONE;
			end
			ST_CHR_WRAP: begin
				cmd.chr_wrap = 1'b1;
				state_d      = ST_CHR_CHECK;
			end
			ST_CHR_CHECK: begin
				if (status.stopped) begin
					state_d = ST_DONE;
				end else if (status.too_tall) begin
					cmd.chr_stop = 1'b1;
					state_d      = ST_DONE;
				end else if (status.scale_zero) begin
					cmd.chr_adv = 1'b1;
					state_d     = ST_DONE;
				end else begin
					state_d = ST_DOT_RD;
				end
			end
			ST_DOT_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_DOT_WR;
			end
			ST_DOT_WR: begin
				cmd.wr_en    = 1'b1;
				cmd.dot_next = 1'b1;
				state_d      = status.dot_last ? ST_CHR_ADV : ST_DOT_RD;
			end
			ST_CHR_ADV: begin
				cmd.chr_adv = 1'b1;
				state_d     = ST_DONE;
			end
			ST_BYTE_RD: begin
				cmd.rd_en = 1'b1;
				cmd.src   = SRC_BYTE;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ rtl/rtfr_datapath.sv @@
// frame store, cursor, dot counters and result register
module rtfr_datapath
	import rtfr_pkg::*;
#(
	parameter int LOGICAL_WIDTH  = LOGICAL_WIDTH_DEF,
	parameter int LOGICAL_HEIGHT = LOGICAL_HEIGHT_DEF,
	parameter int FRAME_BYTES    = FRAME_BYTES_DEF
)
(
	input  logic         clk,
	input  logic         arst_n,
	rtfr_cmd_if.sink     cmd_ch,
	rtfr_rsp_if.source   rsp_ch,
	input  dp_cmd_t      cmd,
	output dp_status_t   status
);

	localparam int AW = $clog2(FRAME_BYTES);
	localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_BYTES - 1);
	localparam logic [7:0] WIDTH_M1 = 8'(LOGICAL_WIDTH - 1);

	logic [7:0] mem [FRAME_BYTES];

	opcode_t    op_q;
	logic [7:0] px_q, py_q, code_q;
	logic       start_q, ink_q;
	logic [3:0] sc_q;
	logic [9:0] addr_q;

	logic [7:0] cx_q, cy_q;
	logic       stop_q, drawn_q;
	logic [7:0] dx_q, dy_q;
	logic [2:0] col_q, row_q;
	logic [3:0] sx_q, sy_q;
	logic [AW-1:0] sweep_q;
	logic [7:0] rdata_q;

	logic       out_valid_q;
	logic [7:0] out_x_q, out_rd_q;
	logic       out_drawn_q;

	logic [3:0]  sc_m1;
	logic [7:0]  dot_x, dot_y, prow, glyph, wdata;
	logic        dot_color, dot_ok, byte_ok;
	logic [31:0] idx_full, addr_full;
	logic [AW-1:0] maddr;
	logic [9:0]  x_span, y_span;

	assign sc_m1 = 4'(sc_q - 4'd1);

	// dot position: the item's pixel or the current dot of a character cell
	always_comb begin
		if (op_q == OP_CHAR) begin
			dot_x = 8'(cx_q + dx_q);
			dot_y = 8'(cy_q + dy_q);
		end else begin
			dot_x = px_q;
			dot_y = py_q;
		end
		glyph = glyph_column(code_q, col_q);
		if (op_q != OP_CHAR) begin
			dot_color = ink_q;
		end else if (col_q == GAP_COL) begin
			dot_color = ~ink_q;
		end else begin
			dot_color = glyph[row_q] ? ink_q : ~ink_q;
		end
	end

	// rotation onto the panel: column y, row width-1-x
	assign prow     = 8'(WIDTH_M1 - dot_x);
	assign idx_full = (32'(prow) >> 3) * 32'(LOGICAL_HEIGHT) + 32'(dot_y);
	assign dot_ok   = (32'(dot_x) < 32'(LOGICAL_WIDTH)) && (32'(dot_y) < 32'(LOGICAL_HEIGHT))
		&& (idx_full < 32'(FRAME_BYTES));
	assign addr_full = 32'(addr_q);
	assign byte_ok   = addr_full < 32'(FRAME_BYTES);

	// store address and write data
	always_comb begin
		unique case (cmd.src)
			SRC_SWEEP: maddr = sweep_q;
			SRC_BYTE:  maddr = addr_full[AW-1:0];
			default:   maddr = idx_full[AW-1:0];
		endcase
		if (cmd.src == SRC_SWEEP) begin
			wdata = (ink_q && !cmd.fill_zero) ? 8'hFF : 8'h00;
		end else if (dot_color) begin
			wdata = rdata_q | (8'h01 << prow[2:0]);
		end else begin
			wdata = rdata_q & ~(8'h01 << prow[2:0]);
		end
	end

	// frame store
	always_ff @(posedge clk) begin
		if (cmd.wr_en && (cmd.src == SRC_SWEEP || dot_ok)) begin
			mem[maddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[maddr];
		end
	end

	// request fields
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= opcode_t'(cmd_ch.opcode);
			px_q    <= cmd_ch.pos_x;
			py_q    <= cmd_ch.pos_y;
			start_q <= cmd_ch.string_start;
			code_q  <= cmd_ch.char_code;
			ink_q   <= cmd_ch.ink;
			sc_q    <= cmd_ch.glyph_scale;
			addr_q  <= cmd_ch.byte_address;
		end
	end

	assign x_span = 10'(cx_q) + 10'(sc_q) * 10'd6;
	assign y_span = 10'(cy_q) + 10'(sc_q) * 10'd7;

	// cursor and string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q    <= '0;
			cy_q    <= '0;
			stop_q  <= 1'b0;
			drawn_q <= 1'b0;
		end else begin
			if (cmd.accept) drawn_q <= 1'b0;
			if (cmd.chr_start && start_q) begin
				cx_q   <= px_q;
				cy_q   <= py_q;
				stop_q <= 1'b0;
			end
			if (cmd.chr_wrap && !stop_q && x_span > 10'(LOGICAL_WIDTH)) begin
				cx_q <= '0;
				cy_q <= 8'(y_span + 10'd1);
			end
			if (cmd.chr_stop) stop_q <= 1'b1;
			if (cmd.chr_adv) begin
				cx_q    <= x_span[7:0];
				drawn_q <= 1'b1;
			end
		end
	end

	// dot counters walk each cell column top to bottom, then left to right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_q <= '0; dy_q <= '0; col_q <= '0; row_q <= '0; sx_q <= '0; sy_q <= '0;
		end else if (cmd.accept) begin
			dx_q <= '0; dy_q <= '0; col_q <= '0; row_q <= '0; sx_q <= '0; sy_q <= '0;
		end else if (cmd.dot_next) begin
			if (sy_q != sc_m1) begin
				sy_q <= 4'(sy_q + 4'd1);
				dy_q <= 8'(dy_q + 8'd1);
			end else if (row_q != GLYPH_LAST_ROW) begin
				sy_q  <= '0;
				row_q <= 3'(row_q + 3'd1);
				dy_q  <= 8'(dy_q + 8'd1);
			end else begin
				sy_q  <= '0;
				row_q <= '0;
				dy_q  <= '0;
				dx_q  <= 8'(dx_q + 8'd1);
				if (sx_q != sc_m1) begin
					sx_q <= 4'(sx_q + 4'd1);
				end else begin
					sx_q  <= '0;
					col_q <= 3'(col_q + 3'd1);
				end
			end
		end
	end

	// fill sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.accept) begin
			sweep_q <= '0;
		end else if (cmd.wr_en && cmd.src == SRC_SWEEP) begin
			sweep_q <= (sweep_q == LAST_IDX) ? '0 : AW'(sweep_q + 1'b1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_x_q     <= (op_q == OP_CHAR) ? cx_q : 8'h00;
			out_drawn_q <= drawn_q;
			out_rd_q    <= (op_q == OP_READ && byte_ok) ? rdata_q : 8'h00;
		end
	end

	assign rsp_ch.valid      = out_valid_q;
	assign rsp_ch.next_x     = out_x_q;
	assign rsp_ch.char_drawn = out_drawn_q;
	assign rsp_ch.read_data  = out_rd_q;

	// status to the controller
	assign status.op         = op_q;
	assign status.stopped    = stop_q;
	assign status.too_tall   = y_span > 10'(LOGICAL_HEIGHT);
	assign status.scale_zero = (sc_q == 4'd0);
	assign status.dot_last   = (col_q == GAP_COL) && (sx_q == sc_m1)
		&& (row_q == GLYPH_LAST_ROW) && (sy_q == sc_m1);
	assign status.sweep_last = (sweep_q == LAST_IDX);
	assign status.out_busy   = out_valid_q && !rsp_ch.ready;

endmodule

@@ rtl/rotated_text_framebuffer_renderer.sv @@
// top level of the rotated text framebuffer renderer
// Requests arrive on the cmd channel and one result per request leaves on the rsp
// channel; both transfer when valid and ready are high at a rising clk edge.
// The frame store is a single-port memory. Steps from the request transfer to the
// result register: clear writes one byte per cycle over the whole store; pixel
// reads, modifies and writes one byte; read byte reads one byte; character reads
// and writes one byte per dot (42 dots at scale one) when drawn, and draws
// nothing when wrapped out or the string stopped.
// cmd.ready is high only while no request is in work; a new request is taken while
// the previous result still waits in the result register.
// After arst_n falls the store is cleared to black by a sweep over all FRAME_BYTES bytes,
// during which no request is taken; cursor and stop flag reset to zero.
// If the receiver stalls, the finished result holds in the register and the next
// request waits at its end until rsp.ready frees the register.
module rotated_text_framebuffer_renderer
	import rtfr_pkg::*;
#(
	parameter int LOGICAL_WIDTH  = LOGICAL_WIDTH_DEF,
	parameter int LOGICAL_HEIGHT = LOGICAL_HEIGHT_DEF,
	parameter int FRAME_BYTES    = FRAME_BYTES_DEF
)
(
	input  logic       clk,
	input  logic       arst_n,
	rtfr_cmd_if.sink   cmd,
	rtfr_rsp_if.source rsp
);

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;
	logic       in_ready;

	assign cmd.ready = in_ready;

	rtfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (in_ready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	rtfr_datapath #(
		.LOGICAL_WIDTH  (LOGICAL_WIDTH),
		.LOGICAL_HEIGHT (LOGICAL_HEIGHT),
		.FRAME_BYTES    (FRAME_BYTES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd),
		.rsp_ch (rsp),
		.cmd    (dp_cmd),
		.status (dp_status)
	);

endmodule

@@ tb/sv/tb_top.sv @@
// testbench for the rotated text framebuffer renderer: directed and random requests checked against a local model
`timescale 1ns / 1ps
module tb_top;
	import rtfr_pkg::*;

	localparam int LW = 64;
	localparam int LH = 128;
	localparam int NBYTES = 1024;
	localparam int RANDOM_ITEMS = 900;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		opcode_t    op;
		logic [7:0] px;
		logic [7:0] py;
		logic       start;
		logic [7:0] code;
		logic       ink;
		logic [3:0] scale;
		logic [9:0] addr;
	} request_t;

	typedef struct packed {
		logic [7:0] nx;
		logic       drawn;
		logic [7:0] rd;
	} answer_t;

	logic clk;
	logic arst_n;
	rtfr_cmd_if cmd ();
	rtfr_rsp_if rsp ();

	rotated_text_framebuffer_renderer dut (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp));

	// model state
	logic [7:0] shadow_store [NBYTES];
	logic [7:0] shadow_cx;
	logic [7:0] shadow_cy;
	logic       shadow_stopped;

	request_t pending_requests [$];
	answer_t  expected_answers [$];
	int       errors;
	longint   cycles;
	int       sent_count;
	int       recv_count;
	int       drawn_count;
	bit       all_queued;
	bit       send_hold;
	int       rsp_hold_cycles;
	bit       rsp_no_idle;
	bit       cmd_no_idle;
	bit       cmd_fired;

	// copy of the font, written independently of the package function
	logic [39:0] font [95] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
		40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
		40'h082A1C2A08, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
		40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
		40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
		40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
		40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
		40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
		40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
		40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
		40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
		40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
		40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
		40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
		40'h7C14141408, 40'h081414147C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
		40'h3C4040407C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
		40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h08082A1C08
	};

	// set or clear one logical dot, coordinates wrap at 8 bits
	function automatic void plot_dot(int x, int y, logic white);
		int prow;
		int idx;
		x = x & 8'hFF;
		y = y & 8'hFF;
		if (x >= LW || y >= LH) return;
		prow = LW - 1 - x;
		idx = (prow >> 3) * LH + y;
		if (idx >= NBYTES) return;
		shadow_store[idx][prow & 7] = white;
	endfunction

	// opaque glyph with trailing background gap
	function automatic void paint_glyph(int x, int y, logic [7:0] code, logic ink, int sc);
		int c;
		logic [7:0] column;
		if (code < 8'd32 || code > 8'd126) code = 8'd63;
		c = code - 32;
		for (int col = 0; col < 5; col++) begin
			column = font[c][39 - 8 * col -: 8];
			for (int row = 0; row < 7; row++)
				for (int sx = 0; sx < sc; sx++)
					for (int sy = 0; sy < sc; sy++)
						plot_dot(x + col * sc + sx, y + row * sc + sy,
							column[row] ? ink : !ink);
		end
		for (int row = 0; row < 7 * sc; row++)
			for (int sx = 0; sx < sc; sx++)
				plot_dot(x + 5 * sc + sx, y + row, !ink);
	endfunction

	// predicted result of one request, updating the shadow state
	function automatic answer_t render_request(request_t r);
		answer_t a;
		int sc;
		a = '0;
		sc = r.scale;
		case (r.op)
			OP_CLEAR: begin
				foreach (shadow_store[i]) shadow_store[i] = {8{r.ink}};
			end
			OP_PIXEL: begin
				plot_dot(r.px, r.py, r.ink);
			end
			OP_CHAR: begin
				if (r.start) begin
					shadow_cx = r.px;
					shadow_cy = r.py;
					shadow_stopped = 1'b0;
				end
				if (!shadow_stopped) begin
					if (int'(shadow_cx) + 6 * sc > LW) begin
						shadow_cx = 8'd0;
						shadow_cy = 8'(int'(shadow_cy) + 7 * sc + 1);
					end
					if (int'(shadow_cy) + 7 * sc > LH) begin
						shadow_stopped = 1'b1;
					end else begin
						paint_glyph(shadow_cx, shadow_cy, r.code, r.ink, sc);
						shadow_cx = 8'(int'(shadow_cx) + 6 * sc);
						a.drawn = 1'b1;
					end
				end
				a.nx = shadow_cx;
			end
			default: begin
				a.rd = shadow_store[r.addr];
			end
		endcase
		return a;
	endfunction

	function automatic request_t blank_request(opcode_t op);
		request_t r;
		r = '0;
		r.op = op;
		r.scale = 4'd1;
		return r;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int pick;
		r.px = 8'($urandom_range(0, 255));
		r.py = 8'($urandom_range(0, 255));
		r.start = $urandom_range(0, 3) == 0;
		r.code = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126));
		r.ink = $urandom_range(0, 3) != 0;
		pick = $urandom_range(0, 99);
		// mostly small scales, a few large and the odd out-of-range one
		if (pick < 70) r.scale = 4'($urandom_range(1, 2));
		else if (pick < 95) r.scale = 4'($urandom_range(3, 8));
		else r.scale = 4'($urandom_range(0, 15));
		r.addr = ($urandom_range(0, 19) == 0) ? 10'($urandom) : 10'($urandom_range(0, 1023));
		pick = $urandom_range(0, 99);
		if (pick < 1) begin
			r.op = OP_CLEAR;
		end else if (pick < 25) begin
			r.op = OP_PIXEL;
			if ($urandom_range(0, 3) != 0) begin
				r.px = 8'($urandom_range(0, LW - 1));
				r.py = 8'($urandom_range(0, LH - 1));
			end
		end else if (pick < 65) begin
			r.op = OP_CHAR;
			if (r.start && $urandom_range(0, 3) != 0) begin
				r.px = 8'($urandom_range(0, LW - 1));
				r.py = 8'($urandom_range(0, LH - 8));
			end
		end else begin
			r.op = OP_READ;
		end
		return r;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// reset and cycle limit
	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_answers.size());
			$display("FAIL");
			$finish;
		end
	end

	// stimulus
	initial begin
		request_t r;
		errors = 0;
		cycles = 0;
		sent_count = 0;
		recv_count = 0;
		drawn_count = 0;
		all_queued = 1'b0;
		send_hold = 1'b0;
		rsp_hold_cycles = 0;
		rsp_no_idle = 1'b0;
		cmd_no_idle = 1'b0;
		foreach (shadow_store[i]) shadow_store[i] = 8'h00;
		shadow_cx = 8'd0;
		shadow_cy = 8'd0;
		shadow_stopped = 1'b0;

		// directed: reads after reset, corner pixels, off-space pixels
		r = blank_request(OP_READ); r.addr = 10'd0; pending_requests.push_back(r);
		r.addr = 10'd1023; pending_requests.push_back(r);
		r = blank_request(OP_PIXEL); r.ink = 1'b1; r.px = 8'd0; r.py = 8'd0;
		pending_requests.push_back(r);
		r.px = 8'd63; r.py = 8'd127; pending_requests.push_back(r);
		r.px = 8'd64; r.py = 8'd5; pending_requests.push_back(r);
		r.px = 8'd255; r.py = 8'd255; pending_requests.push_back(r);
		r = blank_request(OP_READ); r.addr = 10'd896; pending_requests.push_back(r);
		r.addr = 10'd127; pending_requests.push_back(r);
		// directed: string with start, fallback codes, wrap, scale zero and 15
		r = blank_request(OP_CHAR); r.start = 1'b1; r.ink = 1'b1; r.code = 8'h41;
		r.px = 8'd56; pending_requests.push_back(r);
		r.start = 1'b0; r.code = 8'd0; pending_requests.push_back(r);
		r.code = 8'd255; pending_requests.push_back(r);
		r.code = 8'd127; r.ink = 1'b0; pending_requests.push_back(r);
		r.scale = 4'd0; pending_requests.push_back(r);
		r.scale = 4'd8; r.code = 8'd126; r.ink = 1'b1; pending_requests.push_back(r);
		r.scale = 4'd15; pending_requests.push_back(r);
		r.scale = 4'd1; r.code = 8'd32; pending_requests.push_back(r);
		// directed: start near the bottom to stop the string, then restart
		r.start = 1'b1; r.px = 8'd60; r.py = 8'd121; pending_requests.push_back(r);
		r.start = 1'b0; pending_requests.push_back(r);
		r.start = 1'b1; r.px = 8'd255; r.py = 8'd255; pending_requests.push_back(r);
		r = blank_request(OP_READ); r.addr = 10'd0; pending_requests.push_back(r);
		r = blank_request(OP_CLEAR); r.ink = 1'b1; r.start = 1'b1; pending_requests.push_back(r);
		r = blank_request(OP_READ); r.addr = 10'd555; pending_requests.push_back(r);
		r = blank_request(OP_CLEAR); pending_requests.push_back(r);

		// long receiver stall while the sender keeps offering
		wait (pending_requests.size() == 0);
		rsp_hold_cycles = 400;
		for (int i = 0; i < 20; i++) pending_requests.push_back(random_request());
		wait (pending_requests.size() == 0 && rsp_hold_cycles == 0);

		// sender pauses until all results are back
		send_hold = 1'b1;
		wait (expected_answers.size() == 0);
		send_hold = 1'b0;

		// random part; a stretch in the middle without idling on either side
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 300) begin
				wait (pending_requests.size() == 0);
				rsp_no_idle = 1'b1;
				cmd_no_idle = 1'b1;
			end
			if (i == 450) begin
				wait (pending_requests.size() == 0);
				rsp_no_idle = 1'b0;
				cmd_no_idle = 1'b0;
			end
			pending_requests.push_back(random_request());
		end
		wait (pending_requests.size() == 0);
		all_queued = 1'b1;
	end

	// request driver: a new item goes out only when the bus is empty or its item transferred
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
			{cmd.opcode, cmd.pos_x, cmd.pos_y, cmd.string_start, cmd.char_code, cmd.ink,
				cmd.glyph_scale, cmd.byte_address} <= '0;
		end else if (!cmd.valid || cmd_fired) begin
			if (!send_hold && pending_requests.size() > 0
					&& (cmd_no_idle || $urandom_range(0, 99) >= 11)) begin
				cmd.valid <= 1'b1;
				cmd.opcode <= pending_requests[0].op;
				cmd.pos_x <= pending_requests[0].px;
				cmd.pos_y <= pending_requests[0].py;
				cmd.string_start <= pending_requests[0].start;
				cmd.char_code <= pending_requests[0].code;
				cmd.ink <= pending_requests[0].ink;
				cmd.glyph_scale <= pending_requests[0].scale;
				cmd.byte_address <= pending_requests[0].addr;
			end else begin
				cmd.valid <= 1'b0;
			end
		end
	end

	// take the head item off the queue when its transfer happens
	always @(posedge clk) begin
		cmd_fired <= arst_n && cmd.valid && cmd.ready;
		if (arst_n && cmd.valid && cmd.ready) begin
			request_t r;
			r.op = opcode_t'(cmd.opcode);
			r.px = cmd.pos_x;
			r.py = cmd.pos_y;
			r.start = cmd.string_start;
			r.code = cmd.char_code;
			r.ink = cmd.ink;
			r.scale = cmd.glyph_scale;
			r.addr = cmd.byte_address;
			expected_answers.push_back(render_request(r));
			void'(pending_requests.pop_front());
			sent_count <= sent_count + 1;
		end
	end

	// result receiver with random and long stalls
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (rsp_hold_cycles > 0) begin
			rsp.ready <= 1'b0;
			rsp_hold_cycles <= rsp_hold_cycles - 1;
		end else begin
			rsp.ready <= rsp_no_idle || $urandom_range(0, 99) >= 11;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_answers.size() == 0) begin
				$error("result with no request outstanding");
				errors <= errors + 1;
			end else begin
				answer_t e;
				e = expected_answers.pop_front();
				if (rsp.next_x !== e.nx) begin
					$error("next_x expected %0d actual %0d", e.nx, rsp.next_x);
					errors <= errors + 1;
				end
				if (rsp.char_drawn !== e.drawn) begin
					$error("char_drawn expected %0d actual %0d", e.drawn, rsp.char_drawn);
					errors <= errors + 1;
				end
				if (rsp.read_data !== e.rd) begin
					$error("read_data expected %02h actual %02h", e.rd, rsp.read_data);
					errors <= errors + 1;
				end
				if (e.drawn) drawn_count <= drawn_count + 1;
			end
			recv_count <= recv_count + 1;
		end
	end

	// end of run
	initial begin
		wait (all_queued);
		wait (expected_answers.size() == 0);
		repeat (50) @(posedge clk);
		$display("%0d requests sent, %0d results checked, %0d characters drawn",
			sent_count, recv_count, drawn_count);
		if (errors == 0 && expected_answers.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
